// ----- rtl/multi_level_priority_fifo_core_defines.svh -----
// assertion macros used by the priority fifo top level
`ifndef MULTI_LEVEL_PRIORITY_FIFO_CORE_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MLPF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mlpf check failed");

// next-cycle implication, checked through reset as well
`define MLPF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("mlpf check failed");

`endif

// ----- rtl/mlpf_pkg.sv -----
// shared types, constants and helpers for the priority fifo
package mlpf_pkg;

  localparam int LEVELS     = 5;
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);
  localparam int STORE_DEPTH = LEVELS * DEPTH;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_REPLY = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
    logic [2:0]         priority_req;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [2:0]         out_level;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
    logic [LVL_W-1:0]      level;
    logic [1:0]            status;
  } cmd_t;

  // ring position after pos
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    logic [PTR_W-1:0] res;
    if (pos == PTR_W'(DEPTH - 1)) res = '0;
    else res = pos + 1'b1;
    return res;
  endfunction

  // flat store address of a level's ring slot
  function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] pos);
    logic [ADDR_W-1:0] res;
    res = ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(pos);
    return res;
  endfunction

endpackage

// ----- rtl/multi_level_priority_fifo_core.sv -----
// top level of the multi-level priority fifo
//
// Input channel: a transaction (push or pop request in req) is taken at a
// rising edge with push high and full low. Result channel: the oldest result
// sits on rsp while empty is low and is taken at an edge with pop high.
// Every request yields exactly one result, in request order: status ok,
// "all levels empty" for a pop with nothing stored, or "full" for a push to a
// full or out-of-range level. A successful pop returns the head of the
// lowest-numbered non-empty level and that level number.
// A result passes through the command queue, then the entry store read stage,
// then the output register.
// Throughput: one transaction per cycle unless full; the front classifies each
// request combinationally and the back does one store access per cycle.
// When the receiver stalls, the output register and read stage hold, and the
// four-entry command queue absorbs requests until full rises.
// Synchronous reset empties every level and drops any queued or held result;
// the entry store is not cleared and needs no clearing pass.
`include "multi_level_priority_fifo_core_defines.svh"

module multi_level_priority_fifo_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  mlpf_pkg::in_t  req,
  output logic           empty,
  input  logic           pop,
  output mlpf_pkg::out_t rsp
);
  import mlpf_pkg::*;

  logic q_wr;
  logic q_full;
  cmd_t q_wcmd;
  logic q_rd;
  logic q_valid;
  cmd_t q_rcmd;

  assign full = q_full;

  // request classification and level bookkeeping
  mlpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_wcmd)
  );

  // decoupling queue
  mlpf_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wcmd  (q_wcmd),
    .full  (q_full),
    .rd    (q_rd),
    .rcmd  (q_rcmd),
    .valid (q_valid)
  );

  // store access and result holding
  mlpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_rcmd),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

  // checks
  `MLPF_ASSERT_NOW(a_fail_result_zero, !empty && rsp.status != ST_OK, rsp.out_value == 0 && rsp.out_level == 3'd0)
  `MLPF_ASSERT_NOW(a_status_legal, !empty, rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_FULL)
  `MLPF_ASSERT_NOW(a_no_cmd_when_full, q_full, !q_wr)
  `MLPF_ASSERT_NEXT(a_reset_clears, rst, empty && !full)

endmodule

// ----- rtl/mlpf_ram.sv -----
// generic single write port ram with registered read
module mlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mlpf_cmdq.sv -----
// short command queue between the front and back parts
module mlpf_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  mlpf_pkg::cmd_t wcmd,
  output logic          full,
  input  logic          rd,
  output mlpf_pkg::cmd_t rcmd,
  output logic          valid
);
  import mlpf_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign full  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid = (count != '0);
  assign rcmd  = entries[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wcmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/mlpf_front.sv -----
// front part: accepts transactions, tracks level occupancy, issues commands
module mlpf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mlpf_pkg::in_t  req,
  input  logic           q_full,
  output logic           q_wr,
  output mlpf_pkg::cmd_t q_cmd
);
  import mlpf_pkg::*;

  logic [PTR_W-1:0] head  [LEVELS];
  logic [PTR_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic [LEVELS-1:0] lvl_full;
  logic              accept;
  logic              prio_ok;
  logic [LVL_W-1:0]  push_lvl;
  logic              tgt_full;
  logic [PTR_W-1:0]  tgt_tail;
  logic              push_ok;
  logic [LVL_W-1:0]  pick;
  logic              any;
  logic [PTR_W-1:0]  pick_head;
  logic              pop_ok;

  assign accept = push && !q_full;
  assign q_wr   = accept;

  // per-level flags
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      nonempty[l] = (count[l] != '0);
      lvl_full[l] = (count[l] == CNT_W'(DEPTH));
    end
  end

  // push target lookup
  always_comb begin
    prio_ok  = (32'(req.priority_req) < LEVELS);
    push_lvl = LVL_W'(req.priority_req);
    tgt_full = 1'b1;
    tgt_tail = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (push_lvl == LVL_W'(l)) begin
        tgt_full = lvl_full[l];
        tgt_tail = tail[l];
      end
    end
    push_ok = (req.opcode == OP_PUSH) && prio_ok && !tgt_full;
  end

  // priority encoder, lowest level wins
  always_comb begin
    pick      = '0;
    pick_head = '0;
    any       = |nonempty;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        pick      = LVL_W'(l);
        pick_head = head[l];
      end
    end
    pop_ok = (req.opcode == OP_POP) && any;
  end

  // command formation
  always_comb begin
    q_cmd.kind   = CMD_REPLY;
    q_cmd.addr   = '0;
    q_cmd.data   = DATA_WIDTH'($unsigned(req.value));
    q_cmd.level  = '0;
    q_cmd.status = ST_OK;
    if (req.opcode == OP_PUSH) begin
      if (push_ok) begin
        q_cmd.kind = CMD_WRITE;
        q_cmd.addr = store_addr(push_lvl, tgt_tail);
      end else begin
        q_cmd.status = ST_FULL;
      end
    end else begin
      if (pop_ok) begin
        q_cmd.kind  = CMD_READ;
        q_cmd.addr  = store_addr(pick, pick_head);
        q_cmd.level = pick;
      end else begin
        q_cmd.status = ST_EMPTY;
      end
    end
  end

  // ring pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
    end else if (accept) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (push_ok && push_lvl == LVL_W'(l)) begin
          tail[l]  <= ring_next(tail[l]);
          count[l] <= count[l] + 1'b1;
        end
        if (pop_ok && pick == LVL_W'(l)) begin
          head[l]  <= ring_next(head[l]);
          count[l] <= count[l] - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/mlpf_back.sv -----
// back part: executes commands against the entry store and holds the result
module mlpf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mlpf_pkg::cmd_t q_cmd,
  output logic           q_rd,
  output logic           empty,
  input  logic           pop,
  output mlpf_pkg::out_t rsp
);
  import mlpf_pkg::*;

  logic                  s1_valid;
  cmd_t                  s1_cmd;
  logic                  s1_adv;
  logic                  take;
  logic                  out_valid;
  out_t                  out_item;
  out_t                  s1_result;
  logic [DATA_WIDTH-1:0] rdata;

  assign s1_adv = s1_valid && (!out_valid || pop);
  assign take   = q_valid && (!s1_valid || s1_adv);
  assign q_rd   = take;
  assign empty  = !out_valid;
  assign rsp    = out_item;

  // entry store, one ring per level
  mlpf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take && q_cmd.kind == CMD_WRITE),
    .waddr (q_cmd.addr),
    .wdata (q_cmd.data),
    .re    (take && q_cmd.kind == CMD_READ),
    .raddr (q_cmd.addr),
    .rdata (rdata)
  );

  // result formation from the command and read data
  always_comb begin
    s1_result.out_value = '0;
    s1_result.out_level = '0;
    s1_result.status    = s1_cmd.status;
    if (s1_cmd.kind == CMD_READ) begin
      s1_result.out_value = $signed(32'(rdata));
      s1_result.out_level = 3'(s1_cmd.level);
      s1_result.status    = ST_OK;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd <= q_cmd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= s1_result;
    end
  end

endmodule
